// ===== sv/ilc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ilc_pkg
// Shared types and constants for the indexed list core.
// ----------------------------------------------------------------------------
package ilc_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int DATA_W        = 32;
  localparam int OP_W          = 2;
  localparam int POS_W         = 7;
  localparam int STATUS_W      = 3;
  localparam int FOUND_W       = 6;
  localparam int COUNT_OUT_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } ctl_t;

endpackage : ilc_pkg
`default_nettype wire

// ===== sv/ilc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ilc_cell
// One list slot: holds an entry, shifts with its neighbors, compares a key.
// ----------------------------------------------------------------------------
module ilc_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  logic                      clk,
  input  ilc_pkg::ctl_t             ctl,
  input  logic [PW-1:0]             pos,
  input  logic [PW-1:0]             cnt,
  input  logic [ilc_pkg::DATA_W-1:0] value,
  input  logic [ilc_pkg::DATA_W-1:0] prev_data,
  input  logic [ilc_pkg::DATA_W-1:0] next_data,
  output logic [ilc_pkg::DATA_W-1:0] data,
  output logic                      match,
  output logic [ilc_pkg::DATA_W-1:0] pick
);
  import ilc_pkg::*;

  logic at_pos;
  logic above_pos;
  logic held;

  assign at_pos    = (pos == PW'(IDX));
  assign above_pos = (PW'(IDX) > pos);
  assign held      = (PW'(IDX) < cnt);

  assign match = held && (data == value);
  assign pick  = at_pos ? data : '0;

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (above_pos) begin
        data <= prev_data;
      end else if (at_pos) begin
        data <= value;
      end
    end else if (ctl.del) begin
      if (above_pos || at_pos) begin
        data <= next_data;
      end
    end
  end

endmodule : ilc_cell
`default_nettype wire

// ===== sv/indexed_list_insert_delete_search_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_search_core
// Ordered list with insert/delete at index and lowest-index search.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells; an accepted insert or delete shifts
// every cell at once, and a search compares every cell at once. The p1 stage
// registers the compare and shift, the output register the first-match
// encode; a new item is accepted every cycle while the output side keeps up.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_search_core #(
  parameter int DEPTH = ilc_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ilc_pkg::OP_W-1:0]         operation,
  input  logic signed [ilc_pkg::DATA_W-1:0] value,
  input  logic [ilc_pkg::POS_W-1:0]        position,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ilc_pkg::STATUS_W-1:0]     status,
  output logic [ilc_pkg::FOUND_W-1:0]      found_index,
  output logic signed [ilc_pkg::DATA_W-1:0] removed_value,
  output logic [ilc_pkg::COUNT_OUT_W-1:0]  entry_count
);
  import ilc_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int IW = $clog2(DEPTH);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              acc;
  logic [PW-1:0]     pos_e;
  logic [PW-1:0]     cnt_e;
  logic              full;
  logic              ins_ok;
  logic              del_ok;
  logic              srch;
  status_t           pre_status;
  ctl_t              ctl;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] prev_data [DEPTH];
  logic [DATA_W-1:0] next_data [DEPTH];
  logic [DATA_W-1:0] cell_pick [DEPTH];
  logic [DEPTH-1:0]  cell_match;
  logic [DATA_W-1:0] pick_or;

  logic              p1_valid;
  logic              p1_adv;
  status_t           p1_status;
  logic              p1_search;
  logic [DEPTH-1:0]  p1_match;
  logic [DATA_W-1:0] p1_removed;
  logic [CW-1:0]     p1_count;

  logic [DEPTH-1:0]  first_hot;
  logic [IW-1:0]     hit_idx;
  logic              any_hit;

  assign acc   = in_valid && in_ready;
  assign pos_e = PW'(position);
  assign cnt_e = PW'(count);
  assign full  = (count == CW'(DEPTH));

  always_comb begin
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    srch       = 1'b0;
    pre_status = ST_OK;
    count_next = count;
    unique case (operation)
      OP_INSERT: begin
        if (full) begin
          pre_status = ST_FULL;
        end else if (pos_e > cnt_e) begin
          pre_status = ST_BADPOS;
        end else begin
          ins_ok     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_DELETE: begin
        if (count == '0) begin
          pre_status = ST_EMPTY;
        end else if (pos_e >= cnt_e) begin
          pre_status = ST_BADPOS;
        end else begin
          del_ok     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      OP_SEARCH: begin
        if (count == '0) begin
          pre_status = ST_EMPTY;
        end else begin
          srch = 1'b1;
        end
      end
      default: pre_status = ST_BADPOS;
    endcase
  end

  assign ctl.ins = acc && ins_ok;
  assign ctl.del = acc && del_ok;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_data[g] = '0;
    end else begin : g_prev
      assign prev_data[g] = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_data[g] = '0;
    end else begin : g_next
      assign next_data[g] = cell_data[g+1];
    end

    ilc_cell #(
      .IDX (g),
      .PW  (PW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (pos_e),
      .cnt       (cnt_e),
      .value     (value),
      .prev_data (prev_data[g]),
      .next_data (next_data[g]),
      .data      (cell_data[g]),
      .match     (cell_match[g]),
      .pick      (cell_pick[g])
    );
  end

  always_comb begin
    pick_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pick_or = pick_or | cell_pick[i];
    end
  end

  assign p1_adv   = p1_valid && (!out_valid || out_ready);
  assign in_ready = !p1_valid || p1_adv;

  // lowest matching cell
  assign first_hot = p1_match & (~p1_match + DEPTH'(1));
  assign any_hit   = |p1_match;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_hot[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        count    <= count_next;
        p1_valid <= 1'b1;
      end else if (p1_adv) begin
        p1_valid <= 1'b0;
      end
      if (p1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p1_status  <= pre_status;
      p1_search  <= srch;
      p1_match   <= cell_match;
      p1_removed <= del_ok ? pick_or : '0;
      p1_count   <= count_next;
    end
    if (p1_adv) begin
      if (p1_search) begin
        status      <= any_hit ? ST_OK : ST_NOTFOUND;
        found_index <= any_hit ? FOUND_W'(hit_idx) : '0;
      end else begin
        status      <= p1_status;
        found_index <= '0;
      end
      removed_value <= p1_removed;
      entry_count   <= COUNT_OUT_W'(p1_count);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    acc && (operation == OP_INSERT) && full |=> count == $past(count))
    else $error("insert into full list changed count");

  a_side_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (found_index == '0) && (removed_value == '0))
    else $error("failed item carries nonzero index or removed value");

  a_search_count: assert property (@(posedge clk) disable iff (rst)
    acc && (operation == OP_SEARCH) |=> count == $past(count))
    else $error("search changed count");
`endif

endmodule : indexed_list_insert_delete_search_core
`default_nettype wire
